/* rtl/rms_pkg.sv */
// Shared types and constants for the running median sorter.
package rms_pkg;

  localparam int unsigned CAPACITY_DEF = 64;
  localparam int unsigned DATA_W_DEF   = 32;

  // Opcodes carried in the input beat.
  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  typedef struct packed {
    logic               op;
    logic signed [31:0] value;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic               last;
    logic               overflow;
    logic               empty_res;
    logic [6:0]         count;
  } out_beat_t;

  // Control broadcast to every cell of the chain.
  typedef struct packed {
    logic ins;    // sorted insert of the broadcast value
    logic shift;  // move every entry one place towards cell 0
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MEDIAN,
    ST_DRAIN
  } state_t;

endpackage

/* rtl/rms_cell.sv */
// One cell of the sorted insertion chain.
module rms_cell #(
  parameter int unsigned DATA_WIDTH = rms_pkg::DATA_W_DEF
) (
  input  logic                         clk,
  input  rms_pkg::cell_ctrl_t          ctrl,
  input  logic signed [DATA_WIDTH-1:0] ins_val,
  input  logic                         occ,       // this cell holds a value
  input  logic                         left_occ,  // left neighbour holds a value
  input  logic                         left_gt,   // left neighbour is above ins_val
  input  logic signed [DATA_WIDTH-1:0] left_val,
  input  logic signed [DATA_WIDTH-1:0] right_val,
  output logic                         gt,
  output logic signed [DATA_WIDTH-1:0] val
);

  logic signed [DATA_WIDTH-1:0] val_r;
  logic signed [DATA_WIDTH-1:0] val_nxt;
  logic                         take_new;

  // Stored value strictly above the new one: equal values stay in front.
  assign gt       = occ && (ins_val < val_r);
  assign take_new = (gt || !occ) && left_occ && !left_gt;
  assign val      = val_r;

  always_comb begin
    val_nxt = val_r;
    if (ctrl.ins) begin
      if (left_gt) begin
        val_nxt = left_val;
      end else if (take_new) begin
        val_nxt = ins_val;
      end
    end else if (ctrl.shift) begin
      val_nxt = right_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

/* rtl/running_median_sorter_unit.sv */
// Running median sorter: sorted insertion chain with median and drain output.
// Add: the insert cycle of the cell chain is followed by the registered median select into the result beat;
//   the next item is taken only after that beat is loaded, which back-pressure can hold up.
// Add to a full store and drain of an empty store: one result beat, registered in the cycle after acceptance.
// Drain of n values: n result beats, one per cycle while the output is free, the chain shifting towards cell 0.
// Reset (rst_n, synchronous, active low) empties the store and the output register;
//   cell contents are not cleared, only entries below the count are ever read.
module running_median_sorter_unit #(
  parameter int unsigned CAPACITY   = rms_pkg::CAPACITY_DEF,
  parameter int unsigned DATA_WIDTH = rms_pkg::DATA_W_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  rms_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output rms_pkg::out_beat_t out_data
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned IDX_W = $clog2(CAPACITY);

  // ---------------------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------------------
  rms_pkg::state_t    state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               out_valid_r;
  rms_pkg::out_beat_t out_data_r, out_nxt;
  logic               out_load;
  rms_pkg::cell_ctrl_t ctrl;

  logic in_fire;
  logic out_free;
  logic is_add;
  logic full;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == rms_pkg::ST_IDLE) && out_free;
  assign in_fire  = in_valid && in_ready;
  assign is_add   = (in_data.op == rms_pkg::OP_ADD);
  assign full     = (count_r == CNT_W'(CAPACITY));

  // Input value cut to DATA_WIDTH (sign-extended first when wider).
  logic signed [63:0]           in_wide;
  logic signed [DATA_WIDTH-1:0] ins_val;
  assign in_wide = 64'(in_data.value);
  assign ins_val = in_wide[DATA_WIDTH-1:0];

  // ---------------------------------------------------------------------------
  // Cell chain
  // ---------------------------------------------------------------------------
  logic signed [DATA_WIDTH-1:0] cell_val [CAPACITY];
  logic [CAPACITY-1:0]          cell_gt;
  logic [CAPACITY-1:0]          cell_occ;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                         l_occ;
    logic                         l_gt;
    logic signed [DATA_WIDTH-1:0] l_val;
    logic signed [DATA_WIDTH-1:0] r_val;

    assign cell_occ[i] = (CNT_W'(i) < count_r);

    if (i == 0) begin : g_head
      // Nothing sits to the left of the head: behaves as occupied, not above.
      assign l_occ = 1'b1;
      assign l_gt  = 1'b0;
      assign l_val = ins_val;
    end else begin : g_body
      assign l_occ = cell_occ[i-1];
      assign l_gt  = cell_gt[i-1];
      assign l_val = cell_val[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign r_val = cell_val[i];
    end else begin : g_mid
      assign r_val = cell_val[i+1];
    end

    rms_cell #(
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .ins_val   (ins_val),
      .occ       (cell_occ[i]),
      .left_occ  (l_occ),
      .left_gt   (l_gt),
      .left_val  (l_val),
      .right_val (r_val),
      .gt        (cell_gt[i]),
      .val       (cell_val[i])
    );
  end

  // ---------------------------------------------------------------------------
  // Median select: lower median sits at index (count - 1) / 2
  // ---------------------------------------------------------------------------
  logic [CNT_W-1:0]             mid_full;
  logic [IDX_W-1:0]             mid_idx;
  logic signed [DATA_WIDTH-1:0] med;
  logic signed [63:0]           med_wide;
  logic signed [63:0]           head_wide;
  logic [6:0]                   count_out;

  assign mid_full = (count_r - CNT_W'(1)) >> 1;
  assign mid_idx  = mid_full[IDX_W-1:0];

  always_comb begin
    med = cell_val[0];
    for (int i = 0; i < CAPACITY; i++) begin
      if (IDX_W'(i) == mid_idx) begin
        med = cell_val[i];
      end
    end
  end

  assign med_wide  = 64'(med);
  assign head_wide = 64'(cell_val[0]);
  assign count_out = 7'(count_r);

  // ---------------------------------------------------------------------------
  // Sequencer: next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rms_pkg::ST_IDLE: begin
        if (in_fire && is_add && !full) begin
          state_nxt = rms_pkg::ST_MEDIAN;
        end else if (in_fire && !is_add && (count_r != '0)) begin
          state_nxt = rms_pkg::ST_DRAIN;
        end
      end
      rms_pkg::ST_MEDIAN: begin
        if (out_free) begin
          state_nxt = rms_pkg::ST_IDLE;
        end
      end
      rms_pkg::ST_DRAIN: begin
        if (out_free && (count_r == CNT_W'(1))) begin
          state_nxt = rms_pkg::ST_IDLE;
        end
      end
      default: state_nxt = rms_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer: outputs (chain control, count, result beat)
  // ---------------------------------------------------------------------------
  always_comb begin
    ctrl      = '0;
    count_nxt = count_r;
    out_load  = 1'b0;
    out_nxt   = '0;
    unique case (state_r)
      rms_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (is_add && !full) begin
            ctrl.ins  = 1'b1;
            count_nxt = count_r + CNT_W'(1);
          end else if (is_add) begin
            // Store full: value dropped, current median flagged.
            out_load             = 1'b1;
            out_nxt.result_value = med_wide[31:0];
            out_nxt.last         = 1'b1;
            out_nxt.overflow     = 1'b1;
            out_nxt.count        = count_out;
          end else if (count_r == '0) begin
            // Drain of an empty store: single empty beat.
            out_load          = 1'b1;
            out_nxt.last      = 1'b1;
            out_nxt.empty_res = 1'b1;
          end
        end
      end
      rms_pkg::ST_MEDIAN: begin
        if (out_free) begin
          out_load             = 1'b1;
          out_nxt.result_value = med_wide[31:0];
          out_nxt.last         = 1'b1;
          out_nxt.count        = count_out;
        end
      end
      rms_pkg::ST_DRAIN: begin
        if (out_free) begin
          ctrl.shift           = 1'b1;
          count_nxt            = count_r - CNT_W'(1);
          out_load             = 1'b1;
          out_nxt.result_value = head_wide[31:0];
          out_nxt.last         = (count_r == CNT_W'(1));
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rms_pkg::ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload, held until the beat is taken.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("store count above capacity");

  a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rms_pkg::ST_DRAIN) |-> (count_r != '0))
    else $error("drain running on an empty store");

  a_drain_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rms_pkg::ST_DRAIN && out_free && count_r == CNT_W'(1))
      |=> (state_r == rms_pkg::ST_IDLE && count_r == '0 && out_data_r.last))
    else $error("drain did not finish on its last beat");

  a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r >= CNT_W'(2)) |-> !(cell_val[1] < cell_val[0]))
    else $error("chain head out of order");

endmodule
